// ----- rtl/helicity_scaler_yield_diff_unit_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef HELICITY_SCALER_YIELD_DIFF_UNIT_MACROS_SVH
`define HELICITY_SCALER_YIELD_DIFF_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define HSYD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define HSYD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must follow every reset cycle.
`define HSYD_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ----- rtl/hsyd_pkg.sv -----
package hsyd_pkg;

  localparam int SEED_W     = 30;
  localparam int CNT_W      = 32;
  localparam int TS_W       = 32;
  localparam int CH_W       = 5;
  localparam int YIELD_W    = 48;
  localparam int TIME_W     = 40;
  localparam int PHASE_W    = 16;
  localparam int PAT_W      = 32;
  localparam int BITS_W     = 6;
  localparam int DELAY_W    = 4;
  localparam int SIGN_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int MAX_DELAY  = 15;
  localparam int OQ_DEPTH   = 3;
  localparam int OQ_PTR_W   = 2;
  localparam int OQ_CNT_W   = 2;

  // Sign codes
  localparam logic [SIGN_W-1:0] SGN_ZERO  = 2'd0;
  localparam logic [SIGN_W-1:0] SGN_PLUS  = 2'd1;
  localparam logic [SIGN_W-1:0] SGN_MINUS = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_SEED_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_DELAY   = 2'd1;

  localparam logic [BITS_W-1:0]  LOCK_RESET  = 6'd30;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 4'd2;
  localparam logic [BITS_W-1:0]  BITS_MAX    = 6'd63;
  localparam logic [PHASE_W-1:0] PHASE_MAX   = 16'hFFFF;

  typedef struct packed {
    logic              first_word;
    logic              pattern_sync;
    logic              reported_helicity;
    logic [TS_W-1:0]   timestamp;
    logic [CH_W-1:0]   channel;
    logic [CNT_W-1:0]  count;
  } req_t;

  typedef struct packed {
    logic [CH_W-1:0]           out_channel;
    logic [YIELD_W-1:0]        yield_sum;
    logic signed [YIELD_W-1:0] difference_sum;
    logic [TIME_W-1:0]         time_yield;
    logic signed [TIME_W-1:0]  time_difference;
    logic [PHASE_W-1:0]        phase;
    logic [PAT_W-1:0]          pattern_number;
    logic [SEED_W-1:0]         seed_reported;
    logic [SEED_W-1:0]         seed_actual;
    logic [SIGN_W-1:0]         pattern_polarity;
    logic [SIGN_W-1:0]         read_polarity;
  } rsp_t;

  // Pattern state as seen after the last accepted request
  typedef struct packed {
    logic [TIME_W-1:0]  time_yield;
    logic [TIME_W-1:0]  time_diff;
    logic [PHASE_W-1:0] phase;
    logic [PAT_W-1:0]   pattern_number;
    logic [SEED_W-1:0]  seed_reported;
    logic [SEED_W-1:0]  seed_actual;
    logic [SIGN_W-1:0]  pattern_sign;
    logic [SIGN_W-1:0]  read_sign;
  } seq_snap_t;

  // One channel entry of the sum store
  typedef struct packed {
    logic [YIELD_W-1:0] yield_acc;
    logic [YIELD_W-1:0] diff_acc;
  } entry_t;

  // Channel result leaving the store stage
  typedef struct packed {
    logic               valid;
    logic [CH_W-1:0]    channel;
    logic [YIELD_W-1:0] yield_sum;
    logic [YIELD_W-1:0] diff_sum;
  } store_res_t;

  // Feedback bit of the seed generator; an all-zero seed yields zero
  function automatic logic lfsr_bit(input logic [SEED_W-1:0] s);
    return (s == '0) ? 1'b0 : (s[29] ^ s[28] ^ s[27] ^ s[6]);
  endfunction

  function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] s);
    return {s[SEED_W-2:0], lfsr_bit(s)};
  endfunction

  // Advance the seed by delay steps; a small XOR network per output bit
  function automatic logic [SEED_W-1:0] lfsr_advance(input logic [SEED_W-1:0] s,
                                                     input logic [DELAY_W-1:0] delay);
    logic [SEED_W-1:0] st;
    logic [SEED_W-1:0] res;
    st  = s;
    res = s;
    for (int k = 1; k <= MAX_DELAY; k++) begin
      st = lfsr_next(st);
      if (DELAY_W'(k) == delay) res = st;
    end
    return res;
  endfunction

endpackage

// ----- rtl/hsyd_seq.sv -----
module hsyd_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hsyd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsyd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                fire,
  input  hsyd_pkg::req_t                      req,
  output logic                                clear_now,
  output hsyd_pkg::seq_snap_t                 snap
);

  logic [hsyd_pkg::BITS_W-1:0]  lock_seed_bits;
  logic [hsyd_pkg::DELAY_W-1:0] report_delay;
  logic [hsyd_pkg::SEED_W-1:0]  seed_shift;
  logic [hsyd_pkg::SEED_W-1:0]  seed_shift_next;
  logic [hsyd_pkg::BITS_W-1:0]  seed_bit_count;
  logic [hsyd_pkg::BITS_W-1:0]  seed_bit_count_next;
  hsyd_pkg::seq_snap_t          snap_next;
  logic [hsyd_pkg::SEED_W-1:0]  adv;
  logic                         lock;
  logic [hsyd_pkg::TIME_W-1:0]  ty_base;
  logic [hsyd_pkg::TIME_W-1:0]  td_base;
  logic [hsyd_pkg::TIME_W-1:0]  ts_ext;
  logic                         hel;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_seed_bits <= hsyd_pkg::LOCK_RESET;
      report_delay   <= hsyd_pkg::DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hsyd_pkg::CFG_LOCK_SEED_BITS: lock_seed_bits <= cfg_data;
        hsyd_pkg::CFG_REPORT_DELAY:   report_delay   <= cfg_data[hsyd_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign hel    = req.reported_helicity;
  assign ts_ext = {{(hsyd_pkg::TIME_W - hsyd_pkg::TS_W){1'b0}}, req.timestamp};

  // Update seed, sign, phase and time sums on the first word of a read
  always_comb begin
    snap_next           = snap;
    seed_shift_next     = seed_shift;
    seed_bit_count_next = seed_bit_count;
    adv                 = '0;
    lock                = 1'b0;
    clear_now           = 1'b0;
    ty_base             = '0;
    td_base             = '0;
    if (fire && req.first_word) begin
      if (req.pattern_sync) begin
        snap_next.phase          = '0;
        snap_next.pattern_number = snap.pattern_number + 1'b1;
        if (seed_bit_count != hsyd_pkg::BITS_MAX) begin
          seed_bit_count_next = seed_bit_count + 1'b1;
        end
        seed_shift_next = {seed_shift[hsyd_pkg::SEED_W-2:0], hel};
        adv  = hsyd_pkg::lfsr_advance(seed_shift_next, report_delay);
        lock = (seed_bit_count_next > lock_seed_bits) &&
               (hsyd_pkg::lfsr_bit(snap.seed_reported) == hel);
        if (lock) begin
          snap_next.pattern_sign = (adv[0] == hel) ? hsyd_pkg::SGN_PLUS : hsyd_pkg::SGN_MINUS;
          snap_next.seed_actual  = adv;
        end else begin
          snap_next.pattern_sign = hsyd_pkg::SGN_ZERO;
          snap_next.seed_actual  = '0;
        end
        snap_next.seed_reported = seed_shift_next;
      end else if (snap.phase != hsyd_pkg::PHASE_MAX) begin
        snap_next.phase = snap.phase + 1'b1;
      end

      // Flip the pattern sign on a reported helicity of zero
      case (snap_next.pattern_sign)
        hsyd_pkg::SGN_PLUS:  snap_next.read_sign = hel ? hsyd_pkg::SGN_PLUS : hsyd_pkg::SGN_MINUS;
        hsyd_pkg::SGN_MINUS: snap_next.read_sign = hel ? hsyd_pkg::SGN_MINUS : hsyd_pkg::SGN_PLUS;
        default:             snap_next.read_sign = hsyd_pkg::SGN_ZERO;
      endcase

      // Start of a pattern drops all sums before this read is added
      clear_now = (snap_next.phase == '0);
      ty_base   = clear_now ? '0 : snap.time_yield;
      td_base   = clear_now ? '0 : snap.time_diff;
      snap_next.time_yield = ty_base + ts_ext;
      case (snap_next.read_sign)
        hsyd_pkg::SGN_PLUS:  snap_next.time_diff = td_base + ts_ext;
        hsyd_pkg::SGN_MINUS: snap_next.time_diff = td_base - ts_ext;
        default:             snap_next.time_diff = td_base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap           <= '0;
      seed_shift     <= '0;
      seed_bit_count <= '0;
    end else begin
      snap           <= snap_next;
      seed_shift     <= seed_shift_next;
      seed_bit_count <= seed_bit_count_next;
    end
  end

endmodule

// ----- rtl/hsyd_store.sv -----
module hsyd_store #(
  parameter int CHANNELS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  hsyd_pkg::req_t                 req,
  input  logic                           clear_now,
  input  logic [hsyd_pkg::SIGN_W-1:0]    read_sign,
  output hsyd_pkg::store_res_t           res
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  hsyd_pkg::entry_t              mem [CHANNELS];
  hsyd_pkg::entry_t              rdata;
  hsyd_pkg::entry_t              fwd_data;
  hsyd_pkg::entry_t              base;
  hsyd_pkg::entry_t              upd;
  logic                          fwd_hit;
  logic [CHANNELS-1:0]           filled;
  logic [IDX_W-1:0]              rd_idx;
  logic                          rd_in_range;
  logic                          s1_valid;
  logic [IDX_W-1:0]              s1_idx;
  logic                          s1_in_range;
  logic                          s1_clear;
  logic [hsyd_pkg::CH_W-1:0]     s1_channel;
  logic [hsyd_pkg::YIELD_W-1:0]  s1_cnt;
  logic                          wr_en;

  assign rd_idx      = IDX_W'(req.channel);
  assign rd_in_range = int'(req.channel) < CHANNELS;
  assign wr_en       = s1_valid && s1_in_range;

  // Hold the request while its entry is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_idx      <= rd_idx;
      s1_in_range <= rd_in_range;
      s1_clear    <= clear_now;
      s1_channel  <= req.channel;
      s1_cnt      <= {{(hsyd_pkg::YIELD_W - hsyd_pkg::CNT_W){1'b0}}, req.count};
    end
  end

  // Entry memory: registered read, write back from the stage
  always_ff @(posedge clk) begin
    if (wr_en) mem[s1_idx] <= upd;
    if (fire)  rdata <= mem[rd_idx];
  end

  // Forward a write that lands on the entry being read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (fire) begin
      fwd_hit <= wr_en && (s1_idx == rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) fwd_data <= upd;
  end

  // Mark written entries; a pattern start drops them all at once
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (clear_now) begin
      filled <= '0;
    end else if (wr_en) begin
      filled[s1_idx] <= 1'b1;
    end
  end

  // Modify the entry
  always_comb begin
    if (s1_clear) begin
      base = '0;
    end else if (fwd_hit) begin
      base = fwd_data;
    end else if (s1_in_range && filled[s1_idx]) begin
      base = rdata;
    end else begin
      base = '0;
    end
    upd.yield_acc = base.yield_acc + s1_cnt;
    case (read_sign)
      hsyd_pkg::SGN_PLUS:  upd.diff_acc = base.diff_acc + s1_cnt;
      hsyd_pkg::SGN_MINUS: upd.diff_acc = base.diff_acc - s1_cnt;
      default:             upd.diff_acc = base.diff_acc;
    endcase
  end

  assign res.valid     = s1_valid;
  assign res.channel   = s1_channel;
  assign res.yield_sum = s1_in_range ? upd.yield_acc : '0;
  assign res.diff_sum  = s1_in_range ? upd.diff_acc : '0;

endmodule

// ----- rtl/hsyd_outq.sv -----
module hsyd_outq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  hsyd_pkg::rsp_t                  push_data,
  input  logic                            rsp_ready,
  output logic                            rsp_valid,
  output hsyd_pkg::rsp_t                  rsp,
  output logic [hsyd_pkg::OQ_CNT_W-1:0]   count
);

  hsyd_pkg::rsp_t                  slots [hsyd_pkg::OQ_DEPTH];
  logic [hsyd_pkg::OQ_PTR_W-1:0]   wr_ptr;
  logic [hsyd_pkg::OQ_PTR_W-1:0]   rd_ptr;
  logic                            pop;

  localparam logic [hsyd_pkg::OQ_PTR_W-1:0] PTR_LAST =
    hsyd_pkg::OQ_PTR_W'(hsyd_pkg::OQ_DEPTH - 1);

  assign rsp_valid = (count != '0);
  assign rsp       = slots[rd_ptr];
  assign pop       = rsp_valid && rsp_ready;

  // Store results in arrival order
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/helicity_scaler_yield_diff_unit.sv -----
// Helicity scaler yield and difference unit.
// Requests on req carry one scaler channel word; the first word of a read also
// carries the pattern sync, reported helicity and time stamp. Every request
// gives one response on rsp with that channel's pattern sums, the time sums,
// phase, pattern count, seeds and signs as they stand after the request.
// Both channels use valid/ready; cfg is a plain write port (cfg_we, cfg_index,
// cfg_data) for the lock threshold and the reporting delay, used while idle.
// A request is registered in the store stage and then written into the output
// queue, from which its response is offered on rsp.
// Throughput: one request per cycle while req_ready is high; the channel sums
// live in a memory with a registered read, and a write-to-read forward keeps
// back-to-back words on the same channel exact.
// A three-entry output queue lets requests flow while rsp is stalled; req_ready
// drops only when the queue and the store stage together hold three results.
// Reset clears the seed, counters, signs, time sums and the channel valid bits,
// so every channel sum reads zero right after reset; the registers return to a
// threshold of 30 and a delay of 2.
module helicity_scaler_yield_diff_unit #(
  parameter int CHANNELS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  hsyd_pkg::req_t                   req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output hsyd_pkg::rsp_t                   rsp,
  input  logic                             cfg_we,
  input  logic [hsyd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hsyd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                            fire;
  logic                            clear_now;
  hsyd_pkg::seq_snap_t             snap;
  hsyd_pkg::store_res_t            res;
  hsyd_pkg::rsp_t                  push_data;
  logic [hsyd_pkg::OQ_CNT_W-1:0]   q_count;

  // Accept while the queue has room for everything in flight
  assign req_ready = (int'(q_count) + int'(res.valid)) < hsyd_pkg::OQ_DEPTH;
  assign fire      = req_valid && req_ready;

  hsyd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .req       (req),
    .clear_now (clear_now),
    .snap      (snap)
  );

  hsyd_store #(.CHANNELS(CHANNELS)) u_store (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .req       (req),
    .clear_now (clear_now),
    .read_sign (snap.read_sign),
    .res       (res)
  );

  // Merge channel sums with the pattern state of the same request
  always_comb begin
    push_data.out_channel      = res.channel;
    push_data.yield_sum        = res.yield_sum;
    push_data.difference_sum   = res.diff_sum;
    push_data.time_yield       = snap.time_yield;
    push_data.time_difference  = snap.time_diff;
    push_data.phase            = snap.phase;
    push_data.pattern_number   = snap.pattern_number;
    push_data.seed_reported    = snap.seed_reported;
    push_data.seed_actual      = snap.seed_actual;
    push_data.pattern_polarity = snap.pattern_sign;
    push_data.read_polarity    = snap.read_sign;
  end

  hsyd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res.valid),
    .push_data (push_data),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .count     (q_count)
  );

endmodule

// ----- rtl/hsyd_check.sv -----
`include "helicity_scaler_yield_diff_unit_macros.svh"

module hsyd_check #(
  parameter int CHANNELS = 32
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input hsyd_pkg::rsp_t                   rsp
);

  // No response survives reset
  `HSYD_ASSERT_RESET(a_reset_empty, !rsp_valid, "response valid after reset")

  // Stalled response holds
  `HSYD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp),
                    "stalled response changed")

  // Channels outside the store report zero sums
  `HSYD_ASSERT_IMP(a_out_of_range, rsp_valid && (int'(rsp.out_channel) >= CHANNELS),
                   rsp.yield_sum == '0 && rsp.difference_sum == '0,
                   "sums reported for a channel outside the store")

  // Read sign is zero exactly when the pattern sign is unknown
  `HSYD_ASSERT_IMP(a_sign_pair, rsp_valid,
                   (rsp.pattern_polarity == hsyd_pkg::SGN_ZERO) ==
                   (rsp.read_polarity == hsyd_pkg::SGN_ZERO),
                   "read sign and pattern sign disagree on zero")

  // Unlocked predictor reports no advanced seed
  `HSYD_ASSERT_IMP(a_unlocked_seed, rsp_valid && rsp.pattern_polarity == hsyd_pkg::SGN_ZERO,
                   rsp.seed_actual == '0, "advanced seed set while unlocked")

endmodule

bind helicity_scaler_yield_diff_unit hsyd_check #(.CHANNELS(CHANNELS)) u_hsyd_check (.*);

// ----- bench/helicity_scaler_yield_diff_unit_tb.sv -----
`timescale 1ns / 100ps

module helicity_scaler_yield_diff_unit_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_RUN    = 20;
  localparam int HOLD_CYCLES = 80;
  localparam logic [hsyd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [hsyd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [hsyd_pkg::CNT_W-1:0] CNT_MAX = '1;
  localparam logic [hsyd_pkg::TS_W-1:0]  TS_MAX  = '1;

  // Per-pattern sums of the block, predicted one request at a time
  class helicity_sum_board;
    logic [hsyd_pkg::BITS_W-1:0]  lock_bits;
    logic [hsyd_pkg::DELAY_W-1:0] delay;
    logic [hsyd_pkg::SEED_W-1:0]  seed_shift;
    logic [hsyd_pkg::SEED_W-1:0]  last_seed;
    logic [hsyd_pkg::SEED_W-1:0]  adv_seed;
    logic [hsyd_pkg::BITS_W-1:0]  bit_count;
    logic [hsyd_pkg::SIGN_W-1:0]  pat_sign;
    logic [hsyd_pkg::SIGN_W-1:0]  rd_sign;
    logic [hsyd_pkg::PHASE_W-1:0] phase;
    logic [hsyd_pkg::PAT_W-1:0]   pat_count;
    logic [hsyd_pkg::TIME_W-1:0]  ts_yield;
    logic [hsyd_pkg::TIME_W-1:0]  ts_diff;
    logic [hsyd_pkg::YIELD_W-1:0] yields[2**hsyd_pkg::CH_W];
    logic [hsyd_pkg::YIELD_W-1:0] diffs[2**hsyd_pkg::CH_W];
    hsyd_pkg::rsp_t expected_sums[$];
    int errors;
    int checked;

    function new();
      lock_bits  = hsyd_pkg::LOCK_RESET;
      delay      = hsyd_pkg::DELAY_RESET;
      seed_shift = '0;
      last_seed  = '0;
      adv_seed   = '0;
      bit_count  = '0;
      pat_sign   = hsyd_pkg::SGN_ZERO;
      rd_sign    = hsyd_pkg::SGN_ZERO;
      phase      = '0;
      pat_count  = '0;
      errors     = 0;
      checked    = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      ts_yield = '0;
      ts_diff  = '0;
      foreach (yields[i]) begin
        yields[i] = '0;
        diffs[i]  = '0;
      end
    endfunction

    function void configure(logic [hsyd_pkg::BITS_W-1:0] lock,
                            logic [hsyd_pkg::DELAY_W-1:0] dly);
      lock_bits = lock;
      delay     = dly;
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    // Next bit of the 30-bit generator; a zero seed stays at zero
    function logic feedback(logic [hsyd_pkg::SEED_W-1:0] s);
      if (s == '0) return 1'b0;
      return s[29] ^ s[28] ^ s[27] ^ s[6];
    endfunction

    function logic [hsyd_pkg::YIELD_W-1:0] weigh(logic [hsyd_pkg::YIELD_W-1:0] acc,
                                                 logic [hsyd_pkg::YIELD_W-1:0] v,
                                                 logic [hsyd_pkg::SIGN_W-1:0] s);
      case (s)
        hsyd_pkg::SGN_PLUS:  return acc + v;
        hsyd_pkg::SGN_MINUS: return acc - v;
        default:             return acc;
      endcase
    endfunction

    function void note_request(hsyd_pkg::req_t r);
      logic [hsyd_pkg::SEED_W-1:0] prev;
      logic [hsyd_pkg::SEED_W-1:0] walk;
      logic nb;
      hsyd_pkg::rsp_t e;
      if (r.first_word) begin
        // Sync: shift in the reported bit and check it against the prediction
        if (r.pattern_sync) begin
          prev      = last_seed;
          phase     = '0;
          pat_count = pat_count + 1'b1;
          if (bit_count != hsyd_pkg::BITS_MAX) bit_count = bit_count + 1'b1;
          seed_shift = {seed_shift[hsyd_pkg::SEED_W-2:0], r.reported_helicity};
          if (bit_count > lock_bits && feedback(prev) == r.reported_helicity) begin
            walk = seed_shift;
            nb   = r.reported_helicity;
            for (int i = 0; i < int'(delay); i++) begin
              nb   = feedback(walk);
              walk = {walk[hsyd_pkg::SEED_W-2:0], nb};
            end
            pat_sign = (nb == r.reported_helicity) ? hsyd_pkg::SGN_PLUS : hsyd_pkg::SGN_MINUS;
            adv_seed = walk;
          end else begin
            pat_sign = hsyd_pkg::SGN_ZERO;
            adv_seed = '0;
          end
          last_seed = seed_shift;
        end else if (phase != hsyd_pkg::PHASE_MAX) begin
          phase = phase + 1'b1;
        end
        // Read sign follows the pattern sign, flipped for a reported zero
        if (r.reported_helicity) rd_sign = pat_sign;
        else if (pat_sign == hsyd_pkg::SGN_PLUS) rd_sign = hsyd_pkg::SGN_MINUS;
        else if (pat_sign == hsyd_pkg::SGN_MINUS) rd_sign = hsyd_pkg::SGN_PLUS;
        else rd_sign = hsyd_pkg::SGN_ZERO;
        if (phase == '0) clear_sums();
        ts_yield = ts_yield + hsyd_pkg::TIME_W'(r.timestamp);
        ts_diff  = hsyd_pkg::TIME_W'(weigh(hsyd_pkg::YIELD_W'(ts_diff),
                                           hsyd_pkg::YIELD_W'(r.timestamp), rd_sign));
      end
      yields[r.channel] = yields[r.channel] + hsyd_pkg::YIELD_W'(r.count);
      diffs[r.channel]  = weigh(diffs[r.channel], hsyd_pkg::YIELD_W'(r.count), rd_sign);

      e.out_channel      = r.channel;
      e.yield_sum        = yields[r.channel];
      e.difference_sum   = diffs[r.channel];
      e.time_yield       = ts_yield;
      e.time_difference  = ts_diff;
      e.phase            = phase;
      e.pattern_number   = pat_count;
      e.seed_reported    = last_seed;
      e.seed_actual      = adv_seed;
      e.pattern_polarity = pat_sign;
      e.read_polarity    = rd_sign;
      expected_sums.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t: response %0d %s: got %h, want %h", $time, checked, what, got, want);
    endtask

    task check_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report(what, got, want);
    endtask

    task check_response(hsyd_pkg::rsp_t got);
      hsyd_pkg::rsp_t e;
      checked++;
      if (expected_sums.size() == 0) begin
        report("response with nothing pending, channel", 64'(got.out_channel), '0);
        return;
      end
      e = expected_sums.pop_front();
      check_field("out_channel", 64'(got.out_channel), 64'(e.out_channel));
      check_field("yield_sum", 64'(got.yield_sum), 64'(e.yield_sum));
      check_field("difference_sum", 64'(got.difference_sum), 64'(e.difference_sum));
      check_field("time_yield", 64'(got.time_yield), 64'(e.time_yield));
      check_field("time_difference", 64'(got.time_difference), 64'(e.time_difference));
      check_field("phase", 64'(got.phase), 64'(e.phase));
      check_field("pattern_number", 64'(got.pattern_number), 64'(e.pattern_number));
      check_field("seed_reported", 64'(got.seed_reported), 64'(e.seed_reported));
      check_field("seed_actual", 64'(got.seed_actual), 64'(e.seed_actual));
      check_field("pattern_polarity", 64'(got.pattern_polarity), 64'(e.pattern_polarity));
      check_field("read_polarity", 64'(got.read_polarity), 64'(e.read_polarity));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  hsyd_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  hsyd_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [hsyd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hsyd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bit gaps_on = 1'b1;
  int rsp_hold = 0;
  int cycles = 0;
  logic [hsyd_pkg::SEED_W-1:0] stream_seed = '0;
  helicity_sum_board sums;

  helicity_scaler_yield_diff_unit #(
    .CHANNELS(2**hsyd_pkg::CH_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watch both handshakes at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sums.note_request(req);
      if (rsp_valid && rsp_ready) sums.check_response(rsp);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("helicity_scaler_yield_diff_unit: mismatch");
      $finish;
    end
  end

  // Response side: random back-pressure, plus one long hold when asked
  initial begin
    int wait_n;
    while (rst) @(posedge clk);
    forever begin
      if (rsp_hold != 0) begin
        wait_n   = rsp_hold;
        rsp_hold = 0;
      end else begin
        wait_n = gaps_on ? $urandom_range(0, 7) : 0;
      end
      if (wait_n != 0) begin
        rsp_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // Offer one request and hold it until taken
  task automatic send_item(hsyd_pkg::req_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    if (r.first_word && r.pattern_sync)
      stream_seed = {stream_seed[hsyd_pkg::SEED_W-2:0], r.reported_helicity};
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic put(bit first, bit sync, bit hel, logic [hsyd_pkg::TS_W-1:0] ts,
                     logic [hsyd_pkg::CH_W-1:0] ch, logic [hsyd_pkg::CNT_W-1:0] cnt);
    hsyd_pkg::req_t r;
    r.first_word        = first;
    r.pattern_sync      = sync;
    r.reported_helicity = hel;
    r.timestamp         = ts;
    r.channel           = ch;
    r.count             = cnt;
    send_item(r);
  endtask

  // Drop valid and wait for every pending response
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sums.pending() != 0);
  endtask

  task automatic set_config(logic [hsyd_pkg::BITS_W-1:0] lock,
                            logic [hsyd_pkg::DELAY_W-1:0] dly);
    cfg_we    <= 1'b1;
    cfg_index <= hsyd_pkg::CFG_LOCK_SEED_BITS;
    cfg_data  <= lock;
    @(posedge clk);
    cfg_index <= hsyd_pkg::CFG_REPORT_DELAY;
    cfg_data  <= {2'($urandom), dly};
    @(posedge clk);
    // Unused indexes must leave both registers alone
    cfg_index <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B;
    cfg_data  <= hsyd_pkg::CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    sums.configure(lock, dly);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Patterns of scaler reads; sync bits mostly follow the generator so that it locks
  task automatic run_patterns(int n_items);
    int sent;
    int reads;
    int words;
    bit sync;
    bit hel;
    logic [hsyd_pkg::CH_W-1:0] ch;
    sent = 0;
    while (sent < n_items) begin
      reads = $urandom_range(1, 3);
      for (int rd = 0; rd < reads; rd++) begin
        sync = (rd == 0);
        // Break the framing now and then: missing or extra sync
        if ($urandom_range(0, 15) == 0) sync = !sync;
        if (sync) begin
          hel = sums.feedback(stream_seed);
          // Corrupt the stream, or kick a zero seed loose
          if ($urandom_range(0, 9) == 0 ||
              (stream_seed == '0 && $urandom_range(0, 1) != 0)) hel = !hel;
        end else begin
          hel = 1'($urandom_range(0, 1));
        end
        words = $urandom_range(1, 3);
        for (int w = 0; w < words; w++) begin
          if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
          // Favor a few channels so back-to-back hits on one channel happen
          ch = ($urandom_range(0, 1) != 0) ? hsyd_pkg::CH_W'($urandom_range(0, 3)) :
                                             hsyd_pkg::CH_W'($urandom);
          if (w == 0)
            put(1'b1, sync, hel, pick_value(), ch, pick_value());
          else
            put(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, ch,
                pick_value());
          sent++;
        end
      end
    end
  endtask

  initial begin
    sums = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: words before any read, reads before any sync
    put(1'b0, 1'b1, 1'b1, TS_MAX, 5'd0, CNT_MAX);
    put(1'b1, 1'b0, 1'b0, TS_MAX, 5'd31, CNT_MAX);
    put(1'b0, 1'b0, 1'b1, '0, 5'd31, CNT_MAX);
    put(1'b0, 1'b1, 1'b0, 32'h5555_5555, 5'd31, '0);
    put(1'b1, 1'b0, 1'b1, 32'hAAAA_AAAA, 5'd5, 32'h5555_5555);
    // First sync: zero seed predicts zero but too few bits to lock
    put(1'b1, 1'b1, 1'b0, '0, 5'd0, '0);
    put(1'b0, 1'b0, 1'b0, TS_MAX, 5'd0, 32'hAAAA_AAAA);
    drain();

    // No threshold, no delay: lock right away with a plus sign
    set_config('0, '0);
    put(1'b1, 1'b1, 1'b0, 32'h0000_0001, 5'd3, CNT_MAX);
    put(1'b0, 1'b1, 1'b1, TS_MAX, 5'd3, CNT_MAX);
    put(1'b1, 1'b0, 1'b0, TS_MAX, 5'd3, CNT_MAX);
    put(1'b0, 1'b0, 1'b0, '0, 5'd30, 32'h8000_0000);
    put(1'b1, 1'b0, 1'b1, 32'h8000_0000, 5'd30, 32'h0000_0001);
    // Zero seed predicts zero, a one drops the lock
    put(1'b1, 1'b1, 1'b1, TS_MAX, 5'd31, CNT_MAX);
    put(1'b0, 1'b0, 1'b1, 32'h0F0F_0F0F, 5'd31, CNT_MAX);
    // Seed of one predicts zero: lock again
    put(1'b1, 1'b1, 1'b0, 32'hF0F0_F0F0, 5'd21, 32'h0F0F_0F0F);
    put(1'b1, 1'b0, 1'b0, TS_MAX, 5'd10, 32'hF0F0_F0F0);
    put(1'b0, 1'b1, 1'b0, '0, 5'd10, CNT_MAX);
    put(1'b1, 1'b1, 1'b1, '0, 5'd0, '0);
    put(1'b1, 1'b1, 1'b0, TS_MAX, 5'd31, CNT_MAX);
    run_patterns(80);
    drain();

    // Threshold of 63 never locks
    set_config(hsyd_pkg::BITS_MAX, hsyd_pkg::DELAY_W'($urandom));
    run_patterns(80);
    drain();

    // Random settings while the response side holds off and the block fills up
    set_config(hsyd_pkg::BITS_W'($urandom_range(0, 40)), hsyd_pkg::DELAY_W'($urandom));
    gaps_on  = 1'b0;
    rsp_hold = HOLD_CYCLES;
    run_patterns(100);
    drain();

    // Highest useful threshold and longest delay
    set_config(hsyd_pkg::BITS_W'(62), hsyd_pkg::DELAY_W'(hsyd_pkg::MAX_DELAY));
    gaps_on = 1'b1;
    run_patterns(80);
    // One long pattern on one channel, back to back
    gaps_on = 1'b0;
    for (int k = 0; k < LONG_RUN; k++)
      put(1'b1, 1'b0, 1'($urandom_range(0, 1)), TS_MAX, 5'd9, CNT_MAX);
    drain();

    // Back to the reset settings
    set_config(hsyd_pkg::LOCK_RESET, hsyd_pkg::DELAY_RESET);
    gaps_on = 1'b1;
    run_patterns(40);
    drain();

    repeat (10) @(posedge clk);
    if (sums.errors == 0 && sums.pending() == 0) begin
      $display("helicity_scaler_yield_diff_unit: match");
    end else begin
      $display("helicity_scaler_yield_diff_unit: mismatch");
    end
    $finish;
  end

endmodule
